// ===== design/pwl_pkg.sv =====
// Package for the positional word list: sizes, codes, item structs and
// width conversion helpers. No dependencies.
`timescale 1ns / 1ps

package pwl_pkg;

  localparam int DEPTH      = 16;
  localparam int WORD_BITS  = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int WORD_FLD_W = 32;
  localparam int POS_W      = 5;
  localparam int CNT_FLD_W  = 5;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    MODE_PUSH_TOP = 3'd0,
    MODE_PUSH_BOT = 3'd1,
    MODE_INS_AT   = 3'd2,
    MODE_DUMP_BU  = 3'd3,
    MODE_DUMP_TD  = 3'd4,
    MODE_DEL_TOP  = 3'd5,
    MODE_DEL_BOT  = 3'd6,
    MODE_DEL_AT   = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SEL_HOLD  = 2'd0,
    SEL_BELOW = 2'd1,
    SEL_ABOVE = 2'd2,
    SEL_NEW   = 2'd3
  } cell_sel_t;

  typedef struct packed {
    mode_t                  mode;
    logic [WORD_FLD_W-1:0]  word;
    logic [POS_W-1:0]       position;
  } cmd_t;

  typedef struct packed {
    status_t                status;
    logic [WORD_FLD_W-1:0]  word_out;
    logic [CNT_FLD_W-1:0]   entry_count;
    logic                   last;
  } res_t;

  function automatic logic [WORD_FLD_W-1:0] to_field(input logic [WORD_BITS-1:0] v);
    logic [63:0] t;
    t = 64'(v);
    return t[WORD_FLD_W-1:0];
  endfunction

  function automatic logic [WORD_BITS-1:0] from_field(input logic [WORD_FLD_W-1:0] v);
    logic [63:0] t;
    t = 64'(v);
    return t[WORD_BITS-1:0];
  endfunction

endpackage

// ===== design/positional_word_list.sv =====
// Top level of the positional word list: command decode, entry count, dump
// sequencer and the chain of pwl_cell storage cells. Depends on pwl_pkg.
//
//   channel   direction  handshake              payload
//   command   in         start & !busy          cmd   (mode, word, position)
//   result    out        res_valid, one cycle   res   (status, word_out,
//                                                      entry_count, last)
//
// Inserts, deletes and failed operations accept a new item every cycle while
// no dump holds busy; the result appears in the cycle after acceptance.
// A dump of N entries holds busy while the chain rotates once, one result
// per cycle, set by the single cell-chain read port.
// Synchronous reset empties the list; the receiver cannot stall results.
`timescale 1ns / 1ps

module positional_word_list (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  pwl_pkg::cmd_t cmd,
  output logic          res_valid,
  output pwl_pkg::res_t res
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t                       state, state_next;
  logic [pwl_pkg::CNT_W-1:0]    count, count_next;
  logic [pwl_pkg::CNT_W-1:0]    rem, rem_next;
  logic                         dir, dir_next;
  logic                         res_valid_next;
  pwl_pkg::res_t                res_next;

  pwl_pkg::cell_sel_t           sel [pwl_pkg::DEPTH];
  logic [pwl_pkg::WORD_BITS-1:0] q  [pwl_pkg::DEPTH];
  logic [pwl_pkg::WORD_BITS-1:0] bus;
  logic [pwl_pkg::WORD_BITS-1:0] rd_word;
  logic [pwl_pkg::IDX_W-1:0]    rd_idx;
  logic [pwl_pkg::CMP_W-1:0]    pos_c, cnt_c;
  logic [pwl_pkg::CNT_W-1:0]    pos_n, ins_idx, del_idx;

  assign busy    = (state == S_DUMP);
  assign pos_c   = pwl_pkg::CMP_W'(cmd.position);
  assign cnt_c   = pwl_pkg::CMP_W'(count);
  assign pos_n   = pwl_pkg::CNT_W'(cmd.position);
  assign rd_word = q[rd_idx];

  always_comb begin
    unique case (cmd.mode)
      pwl_pkg::MODE_PUSH_TOP: ins_idx = count;
      pwl_pkg::MODE_PUSH_BOT: ins_idx = '0;
      default:                ins_idx = count - pos_n;
    endcase
    unique case (cmd.mode)
      pwl_pkg::MODE_DEL_TOP: del_idx = count - 1'b1;
      pwl_pkg::MODE_DEL_BOT: del_idx = '0;
      default:               del_idx = count - pos_n;
    endcase
  end

  always_comb begin
    state_next           = state;
    count_next           = count;
    rem_next             = rem;
    dir_next             = dir;
    res_valid_next       = 1'b0;
    res_next.status      = pwl_pkg::ST_OK;
    res_next.word_out    = '0;
    res_next.entry_count = pwl_pkg::CNT_FLD_W'(count);
    res_next.last        = 1'b1;
    bus                  = pwl_pkg::from_field(cmd.word);
    rd_idx               = '0;
    for (int i = 0; i < pwl_pkg::DEPTH; i++) sel[i] = pwl_pkg::SEL_HOLD;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          res_valid_next = 1'b1;
          unique case (cmd.mode)
            pwl_pkg::MODE_PUSH_TOP, pwl_pkg::MODE_PUSH_BOT, pwl_pkg::MODE_INS_AT: begin
              if (cmd.mode == pwl_pkg::MODE_INS_AT && pos_c > cnt_c) begin
                res_next.status = pwl_pkg::ST_RANGE;
              end else if (count == pwl_pkg::CNT_W'(pwl_pkg::DEPTH)) begin
                res_next.status = pwl_pkg::ST_FULL;
              end else begin
                for (int i = 0; i < pwl_pkg::DEPTH; i++) begin
                  if (pwl_pkg::CNT_W'(i) == ins_idx) begin
                    sel[i] = pwl_pkg::SEL_NEW;
                  end else if (pwl_pkg::CNT_W'(i) > ins_idx &&
                               pwl_pkg::CNT_W'(i) <= count) begin
                    sel[i] = pwl_pkg::SEL_BELOW;
                  end
                end
                count_next           = count + 1'b1;
                res_next.entry_count = pwl_pkg::CNT_FLD_W'(count_next);
              end
            end
            pwl_pkg::MODE_DUMP_BU, pwl_pkg::MODE_DUMP_TD: begin
              if (count == '0) begin
                res_next.status = pwl_pkg::ST_EMPTY;
              end else begin
                res_valid_next = 1'b0;
                state_next     = S_DUMP;
                rem_next       = count;
                dir_next       = (cmd.mode == pwl_pkg::MODE_DUMP_TD);
              end
            end
            default: begin
              if (count == '0) begin
                res_next.status = pwl_pkg::ST_EMPTY;
              end else if (cmd.mode == pwl_pkg::MODE_DEL_AT &&
                           (pos_c == '0 || pos_c > cnt_c)) begin
                res_next.status = pwl_pkg::ST_RANGE;
              end else begin
                rd_idx = pwl_pkg::IDX_W'(del_idx);
                for (int i = 0; i < pwl_pkg::DEPTH; i++) begin
                  if (pwl_pkg::CNT_W'(i) >= del_idx &&
                      pwl_pkg::CNT_W'(i) + 1'b1 < count) begin
                    sel[i] = pwl_pkg::SEL_ABOVE;
                  end
                end
                count_next           = count - 1'b1;
                res_next.word_out    = pwl_pkg::to_field(rd_word);
                res_next.entry_count = pwl_pkg::CNT_FLD_W'(count_next);
              end
            end
          endcase
        end
      end
      S_DUMP: begin
        // rotate the occupied cells once, reading at the leading end
        rd_idx            = dir ? pwl_pkg::IDX_W'(count - 1'b1) : '0;
        bus               = rd_word;
        res_valid_next    = 1'b1;
        res_next.word_out = pwl_pkg::to_field(rd_word);
        res_next.last     = (rem == pwl_pkg::CNT_W'(1));
        rem_next          = rem - 1'b1;
        for (int i = 0; i < pwl_pkg::DEPTH; i++) begin
          if (dir) begin
            if (i == 0) begin
              sel[i] = pwl_pkg::SEL_NEW;
            end else if (pwl_pkg::CNT_W'(i) < count) begin
              sel[i] = pwl_pkg::SEL_BELOW;
            end
          end else begin
            if (pwl_pkg::CNT_W'(i) + 1'b1 == count) begin
              sel[i] = pwl_pkg::SEL_NEW;
            end else if (pwl_pkg::CNT_W'(i) + 1'b1 < count) begin
              sel[i] = pwl_pkg::SEL_ABOVE;
            end
          end
        end
        if (rem == pwl_pkg::CNT_W'(1)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  for (genvar g = 0; g < pwl_pkg::DEPTH; g++) begin : g_cell
    logic [pwl_pkg::WORD_BITS-1:0] below_w, above_w;
    if (g == 0) begin : g_bot
      assign below_w = '0;
    end else begin : g_mid_b
      assign below_w = q[g-1];
    end
    if (g == pwl_pkg::DEPTH - 1) begin : g_top
      assign above_w = '0;
    end else begin : g_mid_a
      assign above_w = q[g+1];
    end
    pwl_cell u_cell (
      .clk   (clk),
      .sel   (sel[g]),
      .below (below_w),
      .above (above_w),
      .bus   (bus),
      .q     (q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rem       <= '0;
      dir       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rem       <= rem_next;
      dir       <= dir_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= pwl_pkg::CNT_W'(pwl_pkg::DEPTH))
    else $error("entry count above depth");

  a_dump_count_hold: assert property (@(posedge clk) disable iff (rst)
    busy |=> count == $past(count))
    else $error("entry count changed during dump");

  a_mid_run_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last |-> busy)
    else $error("non-final result outside a dump");

  a_dump_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> res_valid && res.last)
    else $error("dump ended without a final result");

  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem != '0 && rem <= count)
    else $error("dump counter out of range");

endmodule

// ===== design/pwl_cell.sv =====
// One storage cell of the word chain: holds one token and loads from its
// lower neighbor, upper neighbor or the shared bus. Depends on pwl_pkg.
`timescale 1ns / 1ps

module pwl_cell (
  input  logic                          clk,
  input  pwl_pkg::cell_sel_t            sel,
  input  logic [pwl_pkg::WORD_BITS-1:0] below,
  input  logic [pwl_pkg::WORD_BITS-1:0] above,
  input  logic [pwl_pkg::WORD_BITS-1:0] bus,
  output logic [pwl_pkg::WORD_BITS-1:0] q
);

  always_ff @(posedge clk) begin
    unique case (sel)
      pwl_pkg::SEL_HOLD:  q <= q;
      pwl_pkg::SEL_BELOW: q <= below;
      pwl_pkg::SEL_ABOVE: q <= above;
      pwl_pkg::SEL_NEW:   q <= bus;
      default:            q <= q;
    endcase
  end

endmodule

// ===== tb/sv/positional_word_list_tb.sv =====
// Self-checking testbench for positional_word_list: a queue-fed driver, an
// in-line list predictor and a result monitor. Depends on pwl_pkg and the RTL.
`timescale 1ns / 1ps

module positional_word_list_tb;
  import pwl_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 107;
  localparam int DRAIN_CYCLES = 24;
  localparam int STALL_LIMIT  = 2000;

  typedef struct {
    cmd_t cmd;
    int   idle_pct;
  } pending_item_t;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  cmd_t cmd   = '0;
  logic busy;
  logic res_valid;
  res_t res;

  pending_item_t   pending_items[$];
  res_t            expected_results[$];
  logic [WORD_BITS-1:0] list_words[DEPTH];
  int              list_count  = 0;
  int              gen_count   = 0;
  int              error_count = 0;
  int              stall_cycles = 0;

  positional_word_list u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res       (res)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic res_t list_result(status_t st, logic [WORD_FLD_W-1:0] w,
                                       int cnt, logic fin);
    res_t r;
    r.status      = st;
    r.word_out    = w;
    r.entry_count = CNT_FLD_W'(cnt);
    r.last        = fin;
    return r;
  endfunction

  task automatic apply_list_op(input cmd_t c);
    int i;
    int idx;
    logic [WORD_BITS-1:0] w;
    case (c.mode)
      MODE_PUSH_TOP, MODE_PUSH_BOT, MODE_INS_AT: begin
        if (c.mode == MODE_INS_AT && c.position > list_count) begin
          expected_results.push_back(list_result(ST_RANGE, '0, list_count, 1'b1));
        end else if (list_count >= DEPTH) begin
          expected_results.push_back(list_result(ST_FULL, '0, list_count, 1'b1));
        end else begin
          if (c.mode == MODE_PUSH_TOP) idx = list_count;
          else if (c.mode == MODE_PUSH_BOT) idx = 0;
          else idx = list_count - int'(c.position);
          for (i = list_count; i > idx; i--) list_words[i] = list_words[i-1];
          list_words[idx] = c.word[WORD_BITS-1:0];
          list_count++;
          expected_results.push_back(list_result(ST_OK, '0, list_count, 1'b1));
        end
      end
      MODE_DUMP_BU, MODE_DUMP_TD: begin
        if (list_count == 0) begin
          expected_results.push_back(list_result(ST_EMPTY, '0, 0, 1'b1));
        end else begin
          for (i = 0; i < list_count; i++) begin
            idx = (c.mode == MODE_DUMP_BU) ? i : list_count - 1 - i;
            expected_results.push_back(list_result(ST_OK, list_words[idx], list_count,
                                                   i + 1 == list_count));
          end
        end
      end
      default: begin
        if (list_count == 0) begin
          expected_results.push_back(list_result(ST_EMPTY, '0, 0, 1'b1));
        end else if (c.mode == MODE_DEL_AT &&
                     (c.position == 0 || c.position > list_count)) begin
          expected_results.push_back(list_result(ST_RANGE, '0, list_count, 1'b1));
        end else begin
          if (c.mode == MODE_DEL_TOP) idx = list_count - 1;
          else if (c.mode == MODE_DEL_BOT) idx = 0;
          else idx = list_count - int'(c.position);
          w = list_words[idx];
          for (i = idx; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
          list_count--;
          expected_results.push_back(list_result(ST_OK, w, list_count, 1'b1));
        end
      end
    endcase
  endtask

  // Queue one item and track the list size it leaves behind.
  task automatic add_item(input mode_t m, input logic [WORD_FLD_W-1:0] w,
                          input logic [POS_W-1:0] p, input int idle);
    pending_item_t it;
    it.cmd.mode     = m;
    it.cmd.word     = w;
    it.cmd.position = p;
    it.idle_pct     = idle;
    pending_items.push_back(it);
    if (m == MODE_PUSH_TOP || m == MODE_PUSH_BOT || m == MODE_INS_AT) begin
      if (!(m == MODE_INS_AT && p > gen_count) && gen_count < DEPTH) gen_count++;
    end else if (m == MODE_DEL_TOP || m == MODE_DEL_BOT || m == MODE_DEL_AT) begin
      if (gen_count > 0 && !(m == MODE_DEL_AT && (p == 0 || p > gen_count)))
        gen_count--;
    end
  endtask

  always @(posedge clk) begin
    logic fire;
    logic [$bits(cmd_t)-1:0] junk;
    if (rst) begin
      start <= 1'b0;
    end else begin
      fire = start && !busy;
      if (fire) begin
        apply_list_op(cmd);
        void'(pending_items.pop_front());
      end
      if (!start || fire) begin
        if (pending_items.size() > 0 &&
            $urandom_range(99, 0) >= pending_items[0].idle_pct) begin
          start <= 1'b1;
          cmd   <= pending_items[0].cmd;
        end else begin
          junk  = $bits(cmd_t)'({$urandom, $urandom});
          start <= 1'b0;
          cmd   <= cmd_t'(junk);
        end
      end
    end
  end

  always @(posedge clk) begin
    res_t e;
    if (!rst && res_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d word_out %h entry_count %0d last %0d",
               res.status, res.word_out, res.entry_count, res.last);
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (res.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, res.status);
          error_count++;
        end
        if (res.word_out !== e.word_out) begin
          $error("word_out: expected %h, got %h", e.word_out, res.word_out);
          error_count++;
        end
        if (res.entry_count !== e.entry_count) begin
          $error("entry_count: expected %0d, got %0d", e.entry_count, res.entry_count);
          error_count++;
        end
        if (res.last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, res.last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || res_valid) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int k;
    int idle;
    int r;
    bit filling;
    mode_t m;
    logic [WORD_FLD_W-1:0] w;
    logic [POS_W-1:0] p;

    add_item(MODE_DUMP_BU, '0, '0, 13);
    add_item(MODE_DUMP_TD, '0, '0, 13);
    add_item(MODE_DEL_TOP, '0, '0, 13);
    add_item(MODE_DEL_BOT, '0, '0, 13);
    add_item(MODE_DEL_AT, '0, 5'd0, 13);
    add_item(MODE_DEL_AT, '0, 5'd31, 13);
    add_item(MODE_INS_AT, 32'h1111_1111, 5'd1, 13);
    add_item(MODE_INS_AT, 32'h0000_0000, 5'd0, 13);
    add_item(MODE_PUSH_TOP, 32'hFFFF_FFFF, '0, 13);
    add_item(MODE_PUSH_BOT, 32'h5A5A_A5A5, '0, 13);
    add_item(MODE_INS_AT, 32'hA5A5_5A5A, 5'd3, 13);
    add_item(MODE_INS_AT, 32'h0F0F_F0F0, 5'd2, 13);
    add_item(MODE_INS_AT, 32'h1234_5678, 5'd31, 13);
    add_item(MODE_DEL_AT, '0, 5'd0, 13);
    add_item(MODE_DEL_AT, '0, 5'd6, 13);
    add_item(MODE_DEL_AT, '0, 5'd31, 13);
    add_item(MODE_DUMP_TD, '0, '0, 13);
    add_item(MODE_DUMP_BU, '0, '0, 13);
    add_item(MODE_DEL_AT, '0, 5'd5, 13);
    add_item(MODE_DEL_AT, '0, 5'd1, 13);
    add_item(MODE_DEL_AT, '0, 5'd2, 13);
    add_item(MODE_DEL_TOP, '0, '0, 13);
    add_item(MODE_DEL_BOT, '0, '0, 13);

    filling = 1'b1;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      idle = (k < RANDOM_ITEMS / 3) ? 13 : (k < 2 * RANDOM_ITEMS / 3) ? 88 : 0;
      if (filling && gen_count == DEPTH && $urandom_range(3, 0) == 0) filling = 1'b0;
      if (!filling && gen_count == 0 && $urandom_range(3, 0) == 0) filling = 1'b1;
      r = $urandom_range(99, 0);
      if (r < 8) m = mode_t'($urandom_range(4, 3));
      else if (r < (filling ? 78 : 33)) m = mode_t'($urandom_range(2, 0));
      else m = mode_t'($urandom_range(7, 5));
      case ($urandom_range(7, 0))
        0:       w = '0;
        1:       w = '1;
        default: w = $urandom;
      endcase
      if ($urandom_range(9, 0) == 0) p = POS_W'($urandom_range(31, 0));
      else p = POS_W'($urandom_range(gen_count + 1, 0));
      add_item(m, w, p, idle);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/pwl_pkg.sv
design/pwl_cell.sv
design/positional_word_list.sv
tb/sv/positional_word_list_tb.sv
